### sv/qte_pkg.sv
// Shared types, constants and functions of the quaternion to Euler angle converter.
package qte_pkg;

	localparam int UNIT_BITS = 30;           // fraction bits of the working format
	localparam int UW        = 32;           // one product in the working format
	localparam int IW        = 34;           // sums such as 2(wx+yz) and 1-2(xx+yy)
	localparam int CW        = 37;           // CORDIC x and y with gain and prerotation
	localparam int ZW        = 28;           // CORDIC angle, 24 fraction bits
	localparam int SQ_BITS   = 31;           // root bits of the pitch cosine
	localparam int AW        = 2 * SQ_BITS;  // radicand width
	localparam int RW        = 33;           // square root remainder
	localparam int MW        = 30;           // pitch sine magnitude below one

	localparam logic signed [ZW-1:0] ANG_HALF_PI = ZW'(26353589);
	localparam logic signed [15:0]   OUT_PI      = 16'sd25736;
	localparam logic signed [15:0]   OUT_HALF_PI = 16'sd12868;
	localparam int                   RND_BIAS    = 1024;
	localparam int                   RND_SHIFT   = 11;

	typedef struct packed {
		logic signed [IW-1:0] sr;
		logic signed [IW-1:0] cr;
		logic signed [IW-1:0] sp;
		logic signed [IW-1:0] sy;
		logic signed [IW-1:0] cy;
		logic                 clamp;
	} side_t;

	// atan(2^-i) in units of 2^-24 rad; for i >= 8 it is 2^(24-i)
	function automatic logic signed [ZW-1:0] angle_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:       r = ZW'(13176795);
			1:       r = ZW'(7778716);
			2:       r = ZW'(4110060);
			3:       r = ZW'(2086331);
			4:       r = ZW'(1047214);
			5:       r = ZW'(524117);
			6:       r = ZW'(262123);
			7:       r = ZW'(131069);
			default: r = (i <= 24) ? ZW'(1 << (24 - i)) : '0;
		endcase
		return r;
	endfunction

	// round to Q3.13, ties toward plus infinity, and clamp to +-lim
	function automatic logic signed [15:0] q13_round(input logic signed [ZW-1:0] z,
		input logic signed [15:0] lim);
		logic signed [ZW:0] t;
		logic signed [ZW:0] s;
		logic signed [ZW:0] l;
		t = {z[ZW-1], z} + (ZW+1)'(RND_BIAS);
		s = t >>> RND_SHIFT;
		l = (ZW+1)'(lim);
		if (s > l) s = l;
		if (s < -l) s = -l;
		return s[15:0];
	endfunction

endpackage

### sv/qte_if.sv
// Handshake channels for quaternion items and Euler angle items.
interface qte_quat_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] quat_x;
	logic signed [SAMPLE_WIDTH-1:0] quat_y;
	logic signed [SAMPLE_WIDTH-1:0] quat_z;
	logic signed [SAMPLE_WIDTH-1:0] quat_w;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [14:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               pitch_clamped;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		input ready);
	modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
		output ready);
endinterface

### sv/qte_front.sv
// Product, sum and radicand stages: three registered stages.
module qte_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] qx,
	input  logic signed [SAMPLE_WIDTH-1:0] qy,
	input  logic signed [SAMPLE_WIDTH-1:0] qz,
	input  logic signed [SAMPLE_WIDTH-1:0] qw,
	output logic        [qte_pkg::AW-1:0]  arg,
	output qte_pkg::side_t                 side
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = 2 * SW;
	localparam int E  = 2 * (SW - 1) - qte_pkg::UNIT_BITS;
	localparam int NP = 9;
	localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_WX = 3, P_YZ = 4;
	localparam int P_WY = 5, P_ZX = 6, P_WZ = 7, P_XY = 8;
	localparam int UW = qte_pkg::UW;
	localparam int IW = qte_pkg::IW;

	logic signed [SW-1:0] op_a [NP];
	logic signed [SW-1:0] op_b [NP];
	logic signed [UW-1:0] prod_s1 [NP];

	always_comb begin
		op_a[P_XX] = qx; op_b[P_XX] = qx;
		op_a[P_YY] = qy; op_b[P_YY] = qy;
		op_a[P_ZZ] = qz; op_b[P_ZZ] = qz;
		op_a[P_WX] = qw; op_b[P_WX] = qx;
		op_a[P_YZ] = qy; op_b[P_YZ] = qz;
		op_a[P_WY] = qw; op_b[P_WY] = qy;
		op_a[P_ZX] = qz; op_b[P_ZX] = qx;
		op_a[P_WZ] = qw; op_b[P_WZ] = qz;
		op_a[P_XY] = qx; op_b[P_XY] = qy;
	end

	for (genvar j = 0; j < NP; j++) begin : g_mul
		logic signed [PW-1:0] p;
		logic signed [UW-1:0] u;
		assign p = op_a[j] * op_b[j];
		if (E >= 0) begin : g_down
			logic signed [PW-1:0] sh;
			assign sh = p >>> E;
			assign u  = UW'(sh);
		end else begin : g_up
			logic signed [PW+UW-1:0] sh;
			assign sh = (PW+UW)'(p) <<< (-E);
			assign u  = UW'(sh);
		end
		always_ff @(posedge clk) begin
			if (en) prod_s1[j] <= u;
		end
	end

	function automatic logic signed [IW-1:0] ext(input logic signed [UW-1:0] v);
		return IW'(v);
	endfunction

	localparam logic signed [IW-1:0] ONE = IW'(1) <<< qte_pkg::UNIT_BITS;

	qte_pkg::side_t       side_c, side_s2, side_s3;
	logic signed [IW-1:0] mag_c;
	logic        [qte_pkg::MW-1:0] mag_s2;

	always_comb begin
		side_c.sr = (ext(prod_s1[P_WX]) + ext(prod_s1[P_YZ])) <<< 1;
		side_c.cr = ONE - ((ext(prod_s1[P_XX]) + ext(prod_s1[P_YY])) <<< 1);
		side_c.sp = (ext(prod_s1[P_WY]) - ext(prod_s1[P_ZX])) <<< 1;
		side_c.sy = (ext(prod_s1[P_WZ]) + ext(prod_s1[P_XY])) <<< 1;
		side_c.cy = ONE - ((ext(prod_s1[P_YY]) + ext(prod_s1[P_ZZ])) <<< 1);
		mag_c = side_c.sp[IW-1] ? -side_c.sp : side_c.sp;
		side_c.clamp = (mag_c >= ONE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c;
			mag_s2  <= side_c.clamp ? '0 : mag_c[qte_pkg::MW-1:0];
			side_s3 <= side_s2;
			arg     <= qte_pkg::AW'(((qte_pkg::MW+1)'(1) << qte_pkg::MW) - (qte_pkg::MW+1)'(mag_s2))
				* qte_pkg::AW'(((qte_pkg::MW+1)'(1) << qte_pkg::MW) + (qte_pkg::MW+1)'(mag_s2));
		end
	end

	assign side = side_s3;
endmodule

### sv/qte_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage.
module qte_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [qte_pkg::AW-1:0]         arg,
	input  qte_pkg::side_t                 side_i,
	output logic [qte_pkg::SQ_BITS-1:0]    root,
	output qte_pkg::side_t                 side_o
);
	localparam int N  = qte_pkg::SQ_BITS;
	localparam int AW = qte_pkg::AW;
	localparam int RW = qte_pkg::RW;

	logic [AW-1:0] a_s [N+1];
	logic [RW-1:0] r_s [N+1];
	logic [N-1:0]  q_s [N+1];
	qte_pkg::side_t sd_s [N+1];

	assign a_s[0]  = arg;
	assign r_s[0]  = '0;
	assign q_s[0]  = '0;
	assign sd_s[0] = side_i;

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic [RW+1:0] rr;
		logic [RW+1:0] t;
		assign rr = {r_s[k-1], a_s[k-1][AW-1 -: 2]};
		assign t  = (RW+2)'({q_s[k-1], 2'b01});
		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]  <= a_s[k-1] << 2;
				sd_s[k] <= sd_s[k-1];
				if (rr >= t) begin
					r_s[k] <= RW'(rr - t);
					q_s[k] <= {q_s[k-1][N-2:0], 1'b1};
				end else begin
					r_s[k] <= RW'(rr);
					q_s[k] <= {q_s[k-1][N-2:0], 1'b0};
				end
			end
		end
	end

	assign root   = q_s[N];
	assign side_o = sd_s[N];
endmodule

### sv/qte_cordic.sv
// Pipelined CORDIC vectoring atan2: one prerotation stage and one stage per step.
module qte_cordic #(
	parameter int ITERATIONS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [qte_pkg::IW-1:0] y_in,
	input  logic signed [qte_pkg::IW-1:0] x_in,
	output logic signed [qte_pkg::ZW-1:0] angle
);
	localparam int CW = qte_pkg::CW;
	localparam int ZW = qte_pkg::ZW;

	logic signed [CW-1:0] x_s [ITERATIONS+1];
	logic signed [CW-1:0] y_s [ITERATIONS+1];
	logic signed [ZW-1:0] z_s [ITERATIONS+1];

	logic signed [CW-1:0] xi, yi;
	assign xi = CW'(x_in);
	assign yi = CW'(y_in);

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			if (xi[CW-1]) begin
				if (!yi[CW-1]) begin
					x_s[0] <= yi; y_s[0] <= -xi; z_s[0] <= qte_pkg::ANG_HALF_PI;
				end else begin
					x_s[0] <= -yi; y_s[0] <= xi; z_s[0] <= -qte_pkg::ANG_HALF_PI;
				end
			end else begin
				x_s[0] <= xi; y_s[0] <= yi; z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= ITERATIONS; k++) begin : g_step
		localparam int I = k - 1;
		localparam logic signed [ZW-1:0] STEP = qte_pkg::angle_step(I);
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[k-1] >>> I;
		assign dy = x_s[k-1] >>> I;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[k-1][CW-1]) begin
					x_s[k] <= x_s[k-1] + dx;
					y_s[k] <= y_s[k-1] - dy;
					z_s[k] <= z_s[k-1] + STEP;
				end else begin
					x_s[k] <= x_s[k-1] - dx;
					y_s[k] <= y_s[k-1] + dy;
					z_s[k] <= z_s[k-1] - STEP;
				end
			end
		end
	end

	assign angle = z_s[ITERATIONS];
endmodule

### sv/quaternion_to_euler_angles_top.sv
// Throughput: one item per cycle while the skid is empty; the pipeline is ITERATIONS + 36
// stages deep, set by the 31 root stages of the pitch cosine followed by the CORDIC steps.
// A one-item skid register behind the output lets a stalled result wait in it while the
// pipeline holds behind it; ready drops only while that register is full.
// Reset (arst_n low, asynchronous) clears the valid bits and the skid; data is not reset.
module quaternion_to_euler_angles_top #(
	parameter int ITERATIONS   = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	qte_quat_if.sink   quat,
	qte_euler_if.source euler
);
	// stages: three front, root bits, prerotation plus steps, output register
	localparam int NST = 3 + qte_pkg::SQ_BITS + ITERATIONS + 2;
	localparam int ZW  = qte_pkg::ZW;

	logic en;
	logic [NST-1:0] vld_s;
	logic skd_vld_q;

	logic [qte_pkg::AW-1:0]       arg;
	qte_pkg::side_t               side_f, side_r;
	logic [qte_pkg::SQ_BITS-1:0]  root;
	logic signed [ZW-1:0]         z_roll, z_pitch, z_yaw;

	// whole pipeline advances together whenever the skid is empty
	assign en         = !skd_vld_q;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], quat.valid};
		end
	end

	qte_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk (clk), .en (en),
		.qx (quat.quat_x), .qy (quat.quat_y), .qz (quat.quat_z), .qw (quat.quat_w),
		.arg (arg), .side (side_f)
	);

	qte_sqrt u_sqrt (
		.clk (clk), .en (en), .arg (arg), .side_i (side_f),
		.root (root), .side_o (side_r)
	);

	qte_cordic #(.ITERATIONS(ITERATIONS)) u_roll (
		.clk (clk), .en (en), .y_in (side_r.sr), .x_in (side_r.cr), .angle (z_roll)
	);

	qte_cordic #(.ITERATIONS(ITERATIONS)) u_pitch (
		.clk (clk), .en (en), .y_in (side_r.sp),
		.x_in (qte_pkg::IW'(root)), .angle (z_pitch)
	);

	qte_cordic #(.ITERATIONS(ITERATIONS)) u_yaw (
		.clk (clk), .en (en), .y_in (side_r.sy), .x_in (side_r.cy), .angle (z_yaw)
	);

	// carry the clamp flag and its direction alongside the CORDIC stages
	logic [1:0] cl_s [ITERATIONS+1];
	always_ff @(posedge clk) begin
		if (en) cl_s[0] <= {side_r.clamp, !side_r.sp[qte_pkg::IW-1]};
	end
	for (genvar k = 1; k <= ITERATIONS; k++) begin : g_cl
		always_ff @(posedge clk) begin
			if (en) cl_s[k] <= cl_s[k-1];
		end
	end

	// output register: round, clamp, pick the saturated pitch
	logic signed [15:0] roll_o_s, yaw_o_s;
	logic signed [14:0] pitch_o_s;
	logic               clamp_o_s;
	logic signed [15:0] pitch_r;

	always_comb begin
		if (cl_s[ITERATIONS][1])
			pitch_r = cl_s[ITERATIONS][0] ? qte_pkg::OUT_HALF_PI : -qte_pkg::OUT_HALF_PI;
		else
			pitch_r = qte_pkg::q13_round(z_pitch, qte_pkg::OUT_HALF_PI);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_o_s  <= qte_pkg::q13_round(z_roll, qte_pkg::OUT_PI);
			yaw_o_s   <= qte_pkg::q13_round(z_yaw, qte_pkg::OUT_PI);
			pitch_o_s <= pitch_r[14:0];
			clamp_o_s <= cl_s[ITERATIONS][1];
		end
	end

	// skid: catch the output item when it stalls as the pipeline moves on
	logic signed [15:0] skd_roll_q, skd_yaw_q;
	logic signed [14:0] skd_pitch_q;
	logic               skd_clamp_q;
	logic               o_vld;

	assign o_vld = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skd_vld_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (euler.ready) skd_vld_q <= 1'b0;
		end else if (o_vld && !euler.ready) begin
			skd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skd_vld_q) begin
			skd_roll_q  <= roll_o_s;
			skd_yaw_q   <= yaw_o_s;
			skd_pitch_q <= pitch_o_s;
			skd_clamp_q <= clamp_o_s;
		end
	end

	assign euler.valid         = skd_vld_q || o_vld;
	assign euler.roll_angle    = skd_vld_q ? skd_roll_q  : roll_o_s;
	assign euler.yaw_angle     = skd_vld_q ? skd_yaw_q   : yaw_o_s;
	assign euler.pitch_angle   = skd_vld_q ? skd_pitch_q : pitch_o_s;
	assign euler.pitch_clamped = skd_vld_q ? skd_clamp_q : clamp_o_s;
endmodule

### sv/qte_check.sv
// Port-level checks of the converter and their binding to the top level.
module qte_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] roll,
	input logic signed [14:0] pitch,
	input logic signed [15:0] yaw,
	input logic               clamped
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(roll) && $stable(pitch)
			&& $stable(yaw) && $stable(clamped))
		else $error("stalled angle item changed or vanished");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> pitch == 15'sd12868 || pitch == -15'sd12868)
		else $error("clamped pitch is not plus or minus half pi");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll <= 16'sd25736 && roll >= -16'sd25736
			&& yaw <= 16'sd25736 && yaw >= -16'sd25736)
		else $error("roll or yaw beyond plus or minus pi");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without an output stall");
endmodule

bind quaternion_to_euler_angles_top qte_check u_qte_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (quat.ready),
	.out_valid (euler.valid),
	.out_ready (euler.ready),
	.roll      (euler.roll_angle),
	.pitch     (euler.pitch_angle),
	.yaw       (euler.yaw_angle),
	.clamped   (euler.pitch_clamped)
);
